// File: sv/inuse_bitmap_entry_scanner_unit_defines.svh
// assertion macros used by the scanner top level
`ifndef INUSE_BITMAP_ENTRY_SCANNER_UNIT_DEFINES_SVH
`define INUSE_BITMAP_ENTRY_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define IBES_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibes check failed");
// antecedent implies consequent in the next cycle
`define IBES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibes check failed");
`else
`define IBES_ASSERT_SAME(label, clk, rst, ante, cons)
`define IBES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/ibes_pkg.sv
// constants and types of the in-use bitmap entry scanner
`default_nettype none

package ibes_pkg;

  // scan geometry and pass limits
  localparam int WORD_BITS       = 64;
  localparam int SCAN_BIT_LIMIT  = 512;
  localparam int SELECT_LIMIT    = 128;
  localparam int COMBINED_CAP    = 128;
  localparam int MAX_TABLE_WORDS = 1024;

  // table size never exceeds the cursor range
  localparam int EFF_MAX_WORDS = (MAX_TABLE_WORDS < 1024) ? MAX_TABLE_WORDS : 1024;

  // field widths
  localparam int FREE_W = 64;
  localparam int IDX_W  = 16;
  localparam int CUR_W  = 10;
  localparam int TW_W   = 11;
  localparam int POS_W  = $clog2(WORD_BITS);
  localparam int PB_W   = $clog2(SCAN_BIT_LIMIT + WORD_BITS);
  localparam int SEL_W  = $clog2(SELECT_LIMIT + WORD_BITS);

  // stream data widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // one result request
  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             entry_valid;
    logic             last_of_item;
    logic             pass_end;
    logic [CUR_W-1:0] next_word;
  } result_t;

  // scan engine state
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } scan_state_t;

endpackage

`default_nettype wire

// File: sv/ibes_scan.sv
// bit-serial scan engine with pass bit and selection counters
`default_nettype none

module ibes_scan
  import ibes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic [WORD_BITS-1:0] load_inuse,
  input  wire logic [IDX_W-1:0]     load_base,
  input  wire logic [CUR_W-1:0]     load_next,
  input  wire logic                 take,
  output logic                      busy,
  output logic                      res_valid,
  output result_t                   res
);

  scan_state_t          state, state_next;
  logic [WORD_BITS-1:0] sr, sr_next;
  logic [POS_W-1:0]     pos, pos_next;
  logic [IDX_W-1:0]     base, base_next;
  logic [CUR_W-1:0]     next_word, next_word_next;
  logic [PB_W-1:0]      pb, pb_next;
  logic [SEL_W-1:0]     sel, sel_next;

  logic             sr_zero;
  logic             rest_zero;
  logic             is_last;
  logic [SEL_W-1:0] sel_after;
  logic [PB_W-1:0]  pb_sum;
  logic             closes;

  // look at the current bit and what is left above it
  assign sr_zero   = ~|sr;
  assign rest_zero = ~|sr[WORD_BITS-1:1];
  assign is_last   = sr_zero || rest_zero;
  assign sel_after = sr_zero ? sel : sel + SEL_W'(1);
  assign pb_sum    = pb + PB_W'(WORD_BITS);
  assign closes    = (pb_sum >= PB_W'(SCAN_BIT_LIMIT)) ||
                     (sel_after >= SEL_W'(SELECT_LIMIT));

  assign busy      = (state == ST_SCAN);
  assign res_valid = (state == ST_SCAN) && (sr_zero || sr[0]);

  // result of the current position, or the empty result
  always_comb begin
    res.entry_index  = sr_zero ? '0 : base + IDX_W'(pos);
    res.entry_valid  = !sr_zero && (32'(sel) < COMBINED_CAP);
    res.last_of_item = is_last;
    res.pass_end     = is_last && closes;
    res.next_word    = next_word;
  end

  // sequencer: one bit position per cycle, stalls while a result waits
  always_comb begin
    state_next     = state;
    sr_next        = sr;
    pos_next       = pos;
    base_next      = base;
    next_word_next = next_word;
    pb_next        = pb;
    sel_next       = sel;
    unique case (state)
      ST_IDLE: begin
        if (load) begin
          sr_next        = load_inuse;
          pos_next       = '0;
          base_next      = load_base;
          next_word_next = load_next;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sr_zero && !sr[0]) begin
          sr_next  = sr >> 1;
          pos_next = pos + POS_W'(1);
        end else if (take) begin
          sr_next  = sr >> 1;
          pos_next = pos + POS_W'(1);
          sel_next = sel_after;
          if (is_last) begin
            state_next = ST_IDLE;
            if (closes) begin
              pb_next  = '0;
              sel_next = '0;
            end else begin
              pb_next = pb_sum;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and counters cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pb    <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      pb    <= pb_next;
      sel   <= sel_next;
    end
  end

  // word payload
  always_ff @(posedge clk) begin
    sr        <= sr_next;
    pos       <= pos_next;
    base      <= base_next;
    next_word <= next_word_next;
  end

endmodule

`default_nettype wire

// File: sv/inuse_bitmap_entry_scanner_unit.sv
// in-use bitmap entry scanner top level
// After a word is accepted, the first result passes the engine state register and the output
// register, leading free bits being skipped in turn. A new word is taken only once the bit-serial
// scan register in the engine is done with the last; top free bits end it early, stalls hold it.
// Reset: synchronous; cursor and pass counters go to zero, table size to one word.
// An accepted word needs no free output slot: results wait in a single output register.
`default_nettype none
`include "inuse_bitmap_entry_scanner_unit_defines.svh"

module inuse_bitmap_entry_scanner_unit
  import ibes_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [TW_W-1:0]        cfg_wdata,     // table_words
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // free_word
  input  wire logic                   s_axis_tuser,  // word_present
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // entry_index, next_word, zero pad
  output logic [1:0]                  m_axis_tuser,  // entry_valid, pass_end
  output logic                        m_axis_tlast   // last_of_item
);

  logic [TW_W-1:0]  table_words;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic             out_valid;
  result_t          out_res;

  logic                 accept;
  logic                 busy;
  logic                 res_valid;
  result_t              res;
  logic                 out_free;
  logic                 out_fire;
  logic [WORD_BITS-1:0] inuse;
  logic [TW_W-1:0]      lim;
  logic [IDX_W-1:0]     base;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // absent word counts as fully allocated
  assign inuse = s_axis_tuser ? ~s_axis_tdata[WORD_BITS-1:0] : '1;
  assign base  = IDX_W'(32'(cursor) * WORD_BITS);

  // effective table size and cursor wrap
  always_comb begin
    lim = table_words;
    if (table_words == '0) begin
      lim = TW_W'(1);
    end else if (32'(table_words) > EFF_MAX_WORDS) begin
      lim = TW_W'(EFF_MAX_WORDS);
    end
    if ({1'b0, cursor} >= lim - TW_W'(1)) begin
      cursor_next = '0;
    end else begin
      cursor_next = cursor + CUR_W'(1);
    end
  end

  // table size register and word cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      table_words <= TW_W'(1);
      cursor      <= '0;
    end else begin
      if (cfg_we) begin
        table_words <= cfg_wdata;
      end
      if (accept) begin
        cursor <= cursor_next;
      end
    end
  end

  ibes_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_inuse (inuse),
    .load_base  (base),
    .load_next  (cursor_next),
    .take       (out_free),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_res.next_word, out_res.entry_index});
  assign m_axis_tuser  = {out_res.pass_end, out_res.entry_valid};
  assign m_axis_tlast  = out_res.last_of_item;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // a word is scanned before the next one is taken
  `IBES_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, accept, !s_axis_tready)
  // a non-final result leaves the engine still on its word
  `IBES_ASSERT_SAME(a_more_results_busy, clk, rst, out_fire && !m_axis_tlast, !s_axis_tready)
  // pass close is flagged only on the final result of a word
  `IBES_ASSERT_SAME(a_pass_end_on_last, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  // a waiting result stays offered until it is taken
  `IBES_ASSERT_NEXT(a_result_held, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

`default_nettype wire
